### rtl/lrpg_pkg.sv
// lrpg_pkg: shared types and constants of the led ramp pattern generator
// used by lrpg_ctrl, lrpg_datapath and led_ramp_pattern_generator
`timescale 1ns / 1ps
`default_nettype none
package lrpg_pkg;

	localparam int DEF_LEVEL_BITS = 8;

	localparam int LEVEL_W = 8;
	localparam int CFG_W   = 8;
	localparam int IDX_W   = 3;
	localparam int LEN_W   = 18;
	localparam int QUO_W   = 18;
	localparam int DELAY_W = 19;
	localparam int COUNT_W = 20;
	localparam int STEP_W  = $clog2(QUO_W);

	localparam int MS_PER_SECOND = 1000;
	localparam int MS_PER_CENTI  = 10;

	typedef enum logic [IDX_W-1:0] {
		REG_START_LEVEL    = 3'd0,
		REG_STOP_LEVEL     = 3'd1,
		REG_TRIANGLE_MODE  = 3'd2,
		REG_SQUARE_DIVISOR = 3'd3,
		REG_LENGTH_SECONDS = 3'd4,
		REG_LENGTH_CENTIS  = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic take;
		logic div_step;
		logic div_finish;
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} status_t;

endpackage
`default_nettype wire

### rtl/lrpg_ctrl.sv
// lrpg_ctrl: handshake control and divider sequencing of the pattern generator
// depends on lrpg_pkg
`timescale 1ns / 1ps
`default_nettype none
module lrpg_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire logic             restart,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output lrpg_pkg::cmd_t        cmd,
	input  wire lrpg_pkg::status_t status
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DIV  = 2'b10
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   taken;

	assign item_stall   = (state_q != ST_IDLE) || (out_valid_q && result_stall);
	assign accept       = item_valid && !item_stall;
	assign taken        = out_valid_q && !result_stall;
	assign result_valid = out_valid_q;

	always_comb begin
		cmd.take       = accept;
		cmd.div_step   = (state_q == ST_DIV);
		cmd.div_finish = (state_q == ST_DIV) && status.div_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				out_valid_q <= 1'b1;
			else if (taken)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && restart)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (status.div_last)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/lrpg_datapath.sv
// lrpg_datapath: config registers, level state, step timer, shift-subtract divider
// and result registers; driven by lrpg_ctrl commands, depends on lrpg_pkg
`timescale 1ns / 1ps
`default_nettype none
module lrpg_datapath #(
	parameter int LEVEL_BITS = lrpg_pkg::DEF_LEVEL_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [lrpg_pkg::IDX_W-1:0]    wr_index,
	input  wire logic [lrpg_pkg::CFG_W-1:0]    wr_data,
	input  wire logic                          tick,
	input  wire logic                          restart,
	input  wire lrpg_pkg::cmd_t                cmd,
	output lrpg_pkg::status_t                  status,
	output logic [lrpg_pkg::LEVEL_W-1:0]       level,
	output logic                               step_event,
	output logic                               fault
);

	localparam int DIV_W = (LEVEL_BITS + 1 > 8) ? LEVEL_BITS + 1 : 8;

	// config registers
	logic [7:0] start_level_q, stop_level_q, square_divisor_q;
	logic [7:0] length_seconds_q, length_centis_q;
	logic       triangle_mode_q;

	// pattern state
	logic [LEVEL_BITS-1:0]       current_level_q, shown_level_q;
	logic                        going_down_q;
	logic [lrpg_pkg::DELAY_W-1:0] step_delay_q;
	logic [lrpg_pkg::COUNT_W-1:0] tick_countdown_q;
	logic                        span_fault_q;

	// divider
	logic [lrpg_pkg::QUO_W-1:0]  dvd_q;
	logic [DIV_W-1:0]            rem_q, dvs_q;
	logic                        dvs_zero_q;
	logic [lrpg_pkg::STEP_W-1:0] step_q;

	// result
	logic [lrpg_pkg::LEVEL_W-1:0] level_q;
	logic                         event_q, fault_q;

	logic [LEVEL_BITS-1:0] s, e, span, v_step, v_adv;
	logic                  down_init, gd_adv;
	logic [DIV_W-1:0]      divisor;
	logic [lrpg_pkg::LEN_W-1:0] len;
	logic [DIV_W:0]        trial;
	logic                  ge;
	logic [DIV_W-1:0]      rem_next;
	logic [lrpg_pkg::QUO_W-1:0] quo_next;
	logic [lrpg_pkg::DELAY_W-1:0] delay_next;
	logic                  zero_span;
	logic                  fires;

	assign s         = LEVEL_BITS'(start_level_q);
	assign e         = LEVEL_BITS'(stop_level_q);
	assign down_init = (s > e);
	assign span      = down_init ? (s - e) : (e - s);
	assign zero_span = (square_divisor_q == 8'd0) && (span == '0);

	always_comb begin
		if (square_divisor_q != 8'd0)
			divisor = DIV_W'(square_divisor_q);
		else if (triangle_mode_q)
			divisor = DIV_W'({span, 1'b0});
		else
			divisor = DIV_W'(span);
	end

	assign len = lrpg_pkg::LEN_W'(length_seconds_q) * lrpg_pkg::LEN_W'(lrpg_pkg::MS_PER_SECOND)
		+ lrpg_pkg::LEN_W'(length_centis_q) * lrpg_pkg::LEN_W'(lrpg_pkg::MS_PER_CENTI);

	// one quotient bit per cycle
	assign trial      = {rem_q, dvd_q[lrpg_pkg::QUO_W-1]};
	assign ge         = trial >= {1'b0, dvs_q};
	assign rem_next   = ge ? DIV_W'(trial - {1'b0, dvs_q}) : DIV_W'(trial);
	assign quo_next   = {dvd_q[lrpg_pkg::QUO_W-2:0], ge};
	assign delay_next = dvs_zero_q ? '0 : lrpg_pkg::DELAY_W'(quo_next);
	assign status.div_last = (step_q == lrpg_pkg::STEP_W'(lrpg_pkg::QUO_W - 1));

	// level advance at a step
	always_comb begin
		gd_adv = going_down_q;
		v_step = going_down_q ? (current_level_q - 1'b1) : (current_level_q + 1'b1);
		v_adv  = v_step;
		if (square_divisor_q != 8'd0) begin
			v_adv = (current_level_q == s) ? e : s;
		end else begin
			if (v_step == e) begin
				if (!triangle_mode_q)
					v_adv = s;
				else
					gd_adv = !going_down_q;
			end
			if (v_adv == s)
				gd_adv = down_init;
		end
	end

	assign fires = tick && !span_fault_q && (tick_countdown_q <= lrpg_pkg::COUNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_level_q    <= 8'd0;
			stop_level_q     <= 8'd255;
			triangle_mode_q  <= 1'b0;
			square_divisor_q <= 8'd0;
			length_seconds_q <= 8'd1;
			length_centis_q  <= 8'd0;
		end else if (wr_en) begin
			case (wr_index)
				lrpg_pkg::REG_START_LEVEL:    start_level_q    <= wr_data;
				lrpg_pkg::REG_STOP_LEVEL:     stop_level_q     <= wr_data;
				lrpg_pkg::REG_TRIANGLE_MODE:  triangle_mode_q  <= wr_data[0];
				lrpg_pkg::REG_SQUARE_DIVISOR: square_divisor_q <= wr_data;
				lrpg_pkg::REG_LENGTH_SECONDS: length_seconds_q <= wr_data;
				lrpg_pkg::REG_LENGTH_CENTIS:  length_centis_q  <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_level_q  <= '0;
			shown_level_q    <= '0;
			going_down_q     <= 1'b0;
			step_delay_q     <= '0;
			tick_countdown_q <= '0;
			span_fault_q     <= 1'b0;
			step_q           <= '0;
		end else begin
			if (cmd.take) begin
				if (restart) begin
					current_level_q <= s;
					shown_level_q   <= s;
					going_down_q    <= down_init;
					span_fault_q    <= zero_span;
					step_q          <= '0;
				end else if (tick && !span_fault_q) begin
					if (fires) begin
						shown_level_q    <= current_level_q;
						current_level_q  <= v_adv;
						going_down_q     <= gd_adv;
						tick_countdown_q <= {step_delay_q, 1'b1};
					end else begin
						tick_countdown_q <= tick_countdown_q - 1'b1;
					end
				end
			end
			if (cmd.div_step)
				step_q <= step_q + 1'b1;
			if (cmd.div_finish) begin
				step_delay_q     <= delay_next;
				tick_countdown_q <= {delay_next, 1'b1};
			end
		end
	end

	// divider operands are latched at the restart transfer
	always_ff @(posedge clk) begin
		if (cmd.take && restart) begin
			dvd_q      <= len;
			dvs_q      <= divisor;
			dvs_zero_q <= (divisor == '0);
			rem_q      <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= quo_next;
			rem_q <= rem_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			if (restart) begin
				level_q <= lrpg_pkg::LEVEL_W'(s);
				event_q <= 1'b0;
				fault_q <= zero_span;
			end else begin
				level_q <= fires ? lrpg_pkg::LEVEL_W'(current_level_q)
					: lrpg_pkg::LEVEL_W'(shown_level_q);
				event_q <= fires;
				fault_q <= span_fault_q;
			end
		end
	end

	assign level      = level_q;
	assign step_event = event_q;
	assign fault      = fault_q;

endmodule
`default_nettype wire

### rtl/led_ramp_pattern_generator.sv
// led_ramp_pattern_generator: one LED brightness ramp / square pattern channel
// instantiates lrpg_ctrl and lrpg_datapath, depends on lrpg_pkg
//
// Input channel (item_valid/item_stall) carries tick and restart; every
// transfer yields exactly one result (level, step_event, fault) on the
// result channel (result_valid/result_stall) in the next cycle, from an
// output register. Tick and idle items can follow every cycle while the
// result side keeps up. A restart item's result is shown at once, then the
// step delay is computed by a shift-subtract divider, one quotient bit per
// cycle over the 18-bit pattern length, and item_stall stays high until
// it is done.
// When the receiver stalls with a result waiting, item_stall is raised and
// the result is held unchanged until it is transferred.
// Registers are written through wr_en/wr_index/wr_data at any edge; write
// them only while no item is in flight.
// Reset clears the pattern state (level 0, step delay 0) and loads the
// register defaults; no result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none
module led_ramp_pattern_generator #(
	parameter int LEVEL_BITS = lrpg_pkg::DEF_LEVEL_BITS
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr_en,
	input  wire logic [lrpg_pkg::IDX_W-1:0] wr_index,
	input  wire logic [lrpg_pkg::CFG_W-1:0] wr_data,
	input  wire logic                       item_valid,
	output logic                            item_stall,
	input  wire logic                       tick,
	input  wire logic                       restart,
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output logic [lrpg_pkg::LEVEL_W-1:0]    level,
	output logic                            step_event,
	output logic                            fault
);

	lrpg_pkg::cmd_t    cmd;
	lrpg_pkg::status_t status;

	lrpg_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.restart      (restart),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.status       (status)
	);

	lrpg_datapath #(
		.LEVEL_BITS (LEVEL_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.tick       (tick),
		.restart    (restart),
		.cmd        (cmd),
		.status     (status),
		.level      (level),
		.step_event (step_event),
		.fault      (fault)
	);

endmodule
`default_nettype wire

### tb/led_ramp_pattern_generator_test.sv
// led_ramp_pattern_generator_test: self-checking bench for the led ramp pattern generator
// drives tick/restart transfers, predicts level, step_event and fault item by item
// depends on lrpg_pkg and led_ramp_pattern_generator
`timescale 1ns / 1ps
module led_ramp_pattern_generator_test;
	import lrpg_pkg::*;

	typedef struct packed {
		logic tick;
		logic restart;
	} lamp_input_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               step;
		logic               flt;
	} lamp_result_t;

	localparam int SETTLE_CYCLES = 40;
	localparam int NUM_PHASES    = 10;
	localparam int PHASE_ITEMS   = 80;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               wr_en = 1'b0;
	logic [IDX_W-1:0]   wr_index = '0;
	logic [CFG_W-1:0]   wr_data = '0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic               tick = 1'b0;
	logic               restart = 1'b0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [LEVEL_W-1:0] level;
	logic               step_event;
	logic               fault;

	// register copies used by the predictor
	logic [7:0] cfg_start = 8'd0;
	logic [7:0] cfg_stop = 8'd255;
	logic       cfg_tri = 1'b0;
	logic [7:0] cfg_sqdiv = 8'd0;
	logic [7:0] cfg_secs = 8'd1;
	logic [7:0] cfg_centis = 8'd0;

	// predicted pattern state
	logic [7:0]  lvl_now = '0;
	logic [7:0]  lvl_shown = '0;
	logic        ramp_down = 1'b0;
	logic [18:0] delay_ticks = '0;
	logic [19:0] ticks_left = '0;
	logic        span_zero = 1'b0;

	lamp_input_t  pending_items[$];
	lamp_result_t expected_levels[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int n_items = 0;
	int n_restarts = 0;
	int n_steps = 0;
	int n_fault_results = 0;

	led_ramp_pattern_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.tick(tick),
		.restart(restart),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.level(level),
		.step_event(step_event),
		.fault(fault)
	);

	always #5 clk = ~clk;

	task automatic predict_level(input lamp_input_t it, output lamp_result_t r);
		int unsigned len_ms;
		int unsigned span;
		int unsigned divisor;
		logic [7:0]  v;
		logic        stepped;
		stepped = 1'b0;
		if (it.restart) begin
			len_ms = cfg_secs * MS_PER_SECOND + cfg_centis * MS_PER_CENTI;
			span = (cfg_start > cfg_stop) ? 32'(cfg_start - cfg_stop)
				: 32'(cfg_stop - cfg_start);
			lvl_now = cfg_start;
			lvl_shown = cfg_start;
			ramp_down = cfg_start > cfg_stop;
			span_zero = 1'b0;
			if (cfg_sqdiv != 0) begin
				divisor = 32'(cfg_sqdiv);
			end else if (span == 0) begin
				span_zero = 1'b1;
				divisor = 0;
			end else begin
				divisor = cfg_tri ? 2 * span : span;
			end
			delay_ticks = (divisor != 0) ? 19'(len_ms / divisor) : '0;
			ticks_left = 20'(2 * delay_ticks + 1);
		end else if (it.tick && !span_zero) begin
			if (ticks_left <= 1) begin
				stepped = 1'b1;
				lvl_shown = lvl_now;
				if (cfg_sqdiv != 0) begin
					lvl_now = (lvl_now == cfg_start) ? cfg_stop : cfg_start;
				end else begin
					v = ramp_down ? lvl_now - 8'd1 : lvl_now + 8'd1;
					// sawtooth jumps back, triangle turns around at the far end
					if (v == cfg_stop) begin
						if (!cfg_tri)
							v = cfg_start;
						else
							ramp_down = ~ramp_down;
					end
					if (v == cfg_start)
						ramp_down = cfg_start > cfg_stop;
					lvl_now = v;
				end
				ticks_left = 20'(2 * delay_ticks + 1);
			end else begin
				ticks_left = ticks_left - 20'd1;
			end
		end
		r.level = lvl_shown;
		r.step = stepped;
		r.flt = span_zero;
	endtask

	// driver: presents the head of pending_items, pops it on transfer
	always @(posedge clk) begin : drive_items
		lamp_result_t r;
		logic         accepted;
		accepted = item_valid && !item_stall;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (accepted) begin
				predict_level(pending_items[0], r);
				expected_levels.push_back(r);
				if (pending_items[0].restart)
					n_restarts++;
				pending_items.pop_front();
				n_items++;
			end
			if (item_valid && !accepted) begin
				// hold the stalled payload
			end else if (pending_items.size() != 0 &&
					$urandom_range(0, 99) >= send_idle_pct) begin
				item_valid <= 1'b1;
				tick <= pending_items[0].tick;
				restart <= pending_items[0].restart;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// monitor: checks each result transfer against the oldest prediction
	always @(posedge clk) begin : check_results
		lamp_result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_levels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with nothing expected: level %0d step %0b fault %0b",
							$time, level, step_event, fault);
				end else begin
					want = expected_levels.pop_front();
					if (step_event)
						n_steps++;
					if (fault)
						n_fault_results++;
					if (level !== want.level || step_event !== want.step || fault !== want.flt) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch: level %0d/%0d step %0b/%0b fault %0b/%0b (exp/got)",
								$time, want.level, level, want.step, step_event, want.flt, fault);
					end
				end
			end
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic push_item(input logic tk, input logic rs);
		lamp_input_t it;
		it.tick = tk;
		it.restart = rs;
		pending_items.push_back(it);
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || expected_levels.size() != 0)
			@(posedge clk);
		// restart divider may still be busy after its result left
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input reg_index_t idx, input logic [7:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			REG_START_LEVEL:    cfg_start = val;
			REG_STOP_LEVEL:     cfg_stop = val;
			REG_TRIANGLE_MODE:  cfg_tri = val[0];
			REG_SQUARE_DIVISOR: cfg_sqdiv = val;
			REG_LENGTH_SECONDS: cfg_secs = val;
			REG_LENGTH_CENTIS:  cfg_centis = val;
			default: ;
		endcase
	endtask

	task automatic program_pattern(input logic [7:0] st, input logic [7:0] sp, input logic tri_on,
			input logic [7:0] sq, input logic [7:0] secs, input logic [7:0] centis);
		put_reg(REG_START_LEVEL, st);
		put_reg(REG_STOP_LEVEL, sp);
		put_reg(REG_TRIANGLE_MODE, {7'd0, tri_on});
		put_reg(REG_SQUARE_DIVISOR, sq);
		put_reg(REG_LENGTH_SECONDS, secs);
		put_reg(REG_LENGTH_CENTIS, centis);
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	initial begin : stimulus
		logic [7:0] st;
		logic [7:0] sp;
		int         pick;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// defaults, ticks before any restart, idle items, restart together with tick
		push_item(1, 0);
		push_item(1, 0);
		push_item(0, 0);
		push_item(1, 1);
		repeat (5) push_item(1, 0);
		push_item(0, 0);
		wait_idle();

		// zero ramp span raises the fault and holds the level
		program_pattern(8'd40, 8'd40, 1'b0, 8'd0, 8'd1, 8'd0);
		@(negedge clk);
		push_item(0, 1);
		push_item(1, 0);
		push_item(1, 0);
		wait_idle();

		// downward triangle with no length; the first tick still sees the old fault
		program_pattern(8'd200, 8'd197, 1'b1, 8'd0, 8'd0, 8'd0);
		@(negedge clk);
		push_item(1, 0);
		push_item(0, 1);
		repeat (5) push_item(1, 0);
		wait_idle();

		// fastest square wave
		program_pattern(8'd17, 8'd230, 1'b0, 8'd1, 8'd0, 8'd0);
		@(negedge clk);
		push_item(0, 1);
		repeat (4) push_item(1, 0);
		wait_idle();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: program_pattern(8'd0, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0);
				1: program_pattern(8'd255, 8'd0, 1'b1, 8'd0, 8'd0, 8'd255);
				2: program_pattern(8'd0, 8'd255, 1'b0, 8'd255, 8'd255, 8'd255);
				default: begin
					st = 8'($urandom_range(0, 255));
					pick = $urandom_range(0, 3);
					if (pick == 0)
						sp = 8'($urandom_range(0, 255));
					else if (pick == 1)
						sp = st + 8'($urandom_range(1, 6));
					else if (pick == 2)
						sp = st - 8'($urandom_range(1, 6));
					else
						sp = st;
					program_pattern(st, sp, 1'($urandom_range(0, 1)),
						$urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255)),
						($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 2)) : 8'd0,
						$urandom_range(0, 1) ? 8'($urandom_range(0, 30)) : 8'($urandom_range(0, 255)));
				end
			endcase
			@(negedge clk);
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 59; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 59; end
				default: begin send_idle_pct = 20; stall_pct = 20; end
			endcase
			// most phases reload first; the rest run on with live register values
			if ($urandom_range(0, 3) != 0)
				push_item(0, 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 2)
					push_item(0, 1);
				else if (pick < 4)
					push_item(1, 1);
				else if (pick < 80)
					push_item(1, 0);
				else
					push_item(0, 0);
			end
			wait_idle();
		end

		$display("covered %0d transfers, %0d restarts, %0d step events, %0d faulted results",
			n_items, n_restarts, n_steps, n_fault_results);
		$display("over %0d pattern settings, %0d mismatches", NUM_PHASES + 4, mismatches);
		if (mismatches == 0 && expected_levels.size() == 0)
			$display("led_ramp_pattern_generator_test: PASS");
		else
			$display("led_ramp_pattern_generator_test: FAIL");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("led_ramp_pattern_generator_test: FAIL");
		$finish;
	end

endmodule
